@@ rtl/core/line_frame_id_payload_parser_defines.svh @@
// Assertion macros used by the line frame parser datapath.
`ifndef LINE_FRAME_ID_PAYLOAD_PARSER_DEFINES_SVH
`define LINE_FRAME_ID_PAYLOAD_PARSER_DEFINES_SVH

// Check that a condition holds on every clock edge outside reset.
`define LFP_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a consequent holds in the same cycle as its antecedent.
`define LFP_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Check that a consequent holds in the cycle after its antecedent.
`define LFP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/lfp_pkg.sv @@
// Package with types, codes and constants of the line frame parser.
package lfp_pkg;

    localparam int DEF_MAX_PAYLOAD = 32;
    localparam int LEN_W           = 6;
    localparam int BYTE_W          = 8;
    localparam int KIND_W          = 2;

    localparam logic [BYTE_W-1:0] CH_OPEN    = 8'h3C;
    localparam logic [BYTE_W-1:0] CH_COLON   = 8'h3A;
    localparam logic [BYTE_W-1:0] CH_CLOSE   = 8'h3E;
    localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_PLUS    = 8'h2B;
    localparam logic [BYTE_W-1:0] CH_MINUS   = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE    = 8'h39;
    localparam logic [BYTE_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [BYTE_W-1:0] CH_TAB     = 8'h09;
    localparam logic [BYTE_W-1:0] CH_VTAB    = 8'h0B;
    localparam logic [BYTE_W-1:0] CH_FFEED   = 8'h0C;
    localparam logic [BYTE_W-1:0] CH_CR      = 8'h0D;

    localparam logic [KIND_W-1:0] KIND_HEADER = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DATA   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DROP   = 2'd2;

    localparam logic CAUSE_MALFORMED = 1'b0;
    localparam logic CAUSE_OVERFLOW  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HEADER,
        ST_PUSH
    } lfp_state_t;

    typedef enum logic [1:0] {
        PH_WAIT,
        PH_ID,
        PH_DATA,
        PH_DONE
    } lfp_phase_t;

    typedef enum logic [1:0] {
        ID_SPACE,
        ID_SIGN,
        ID_DIGITS,
        ID_STOP
    } lfp_id_phase_t;

    typedef struct packed {
        logic accept;
        logic load_header;
        logic load_data;
        logic idx_clear;
    } lfp_cmd_t;

    typedef struct packed {
        logic newline;
        logic single;
        logic idx_last;
        logic out_free;
    } lfp_sts_t;

endpackage

@@ rtl/core/lfp_ctrl.sv @@
// Controller state machine: byte intake and frame emission sequencing.
module lfp_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  lfp_pkg::lfp_sts_t sts,
    output lfp_pkg::lfp_cmd_t cmd
);
    import lfp_pkg::*;

    lfp_state_t state_reg;
    lfp_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        s_axis_tready   = 1'b0;
        cmd.accept      = 1'b0;
        cmd.load_header = 1'b0;
        cmd.load_data   = 1'b0;
        cmd.idx_clear   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                cmd.accept    = s_axis_tvalid;
                cmd.idx_clear = 1'b1;
                if (s_axis_tvalid && sts.newline)
                begin
                    state_next = ST_HEADER;
                end
            end
            ST_HEADER:
            begin
                cmd.idx_clear = 1'b1;
                if (sts.out_free)
                begin
                    cmd.load_header = 1'b1;
                    state_next      = sts.single ? ST_IDLE : ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                if (sts.out_free)
                begin
                    cmd.load_data = 1'b1;
                    if (sts.idx_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/core/lfp_datapath.sv @@
// Datapath: line parser registers, payload buffer and output register.
`include "line_frame_id_payload_parser_defines.svh"

module lfp_datapath #(
    parameter int MAX_PAYLOAD = lfp_pkg::DEF_MAX_PAYLOAD
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  lfp_pkg::lfp_cmd_t           cmd,
    output lfp_pkg::lfp_sts_t           sts,
    input  logic [lfp_pkg::BYTE_W-1:0]  rx_byte,
    input  logic                        out_ready,
    output logic                        out_valid,
    output logic [lfp_pkg::KIND_W-1:0]  kind,
    output logic [lfp_pkg::BYTE_W-1:0]  device_id,
    output logic [lfp_pkg::LEN_W-1:0]   payload_len,
    output logic [lfp_pkg::BYTE_W-1:0]  data_byte,
    output logic                        drop_cause,
    output logic                        last
);
    import lfp_pkg::*;

    localparam int IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PAYLOAD);

    lfp_phase_t          phase_reg;
    lfp_phase_t          phase_next;
    lfp_id_phase_t       id_phase_reg;
    lfp_id_phase_t       id_phase_next;
    logic [BYTE_W-1:0]   id_accum_reg;
    logic [BYTE_W-1:0]   id_accum_next;
    logic                id_negative_reg;
    logic                id_negative_next;
    logic [LEN_W-1:0]    count_reg;
    logic [LEN_W-1:0]    count_next;
    logic                overflowed_reg;
    logic                overflowed_next;
    logic [LEN_W-1:0]    idx_reg;
    logic [LEN_W-1:0]    idx_next;
    logic                out_valid_reg;

    logic [BYTE_W-1:0]   mem [MAX_PAYLOAD];
    logic [BYTE_W-1:0]   mem_q_reg;
    logic [BYTE_W-1:0]   snap_id_reg;
    logic [LEN_W-1:0]    snap_len_reg;
    logic                snap_drop_reg;
    logic                snap_cause_reg;

    logic [KIND_W-1:0]   kind_reg;
    logic [BYTE_W-1:0]   device_id_reg;
    logic [LEN_W-1:0]    payload_len_reg;
    logic [BYTE_W-1:0]   data_byte_reg;
    logic                drop_cause_reg;
    logic                last_reg;

    logic                is_newline;
    logic                is_space;
    logic                is_digit;
    logic                is_sign;
    logic [BYTE_W-1:0]   acc_step;
    logic                store_en;
    logic [LEN_W-1:0]    rd_addr;
    logic                out_free;

    assign is_newline = (rx_byte == CH_NEWLINE);
    assign is_space   = (rx_byte == CH_SPACE) || (rx_byte == CH_TAB) || (rx_byte == CH_VTAB)
                     || (rx_byte == CH_FFEED) || (rx_byte == CH_CR);
    assign is_digit   = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
    assign is_sign    = (rx_byte == CH_PLUS) || (rx_byte == CH_MINUS);
    assign acc_step   = id_accum_reg * 8'd10 + (rx_byte - CH_ZERO);
    assign store_en   = cmd.accept && !is_newline && (phase_reg == PH_DATA)
                     && (rx_byte != CH_CLOSE) && (count_reg < MAX_LEN);
    assign out_free   = !out_valid_reg || out_ready;

    assign sts.newline  = is_newline;
    assign sts.single   = snap_drop_reg || (snap_len_reg == '0);
    assign sts.idx_last = ((idx_reg + LEN_W'(1)) == snap_len_reg);
    assign sts.out_free = out_free;

    always_comb
    begin
        phase_next       = phase_reg;
        id_phase_next    = id_phase_reg;
        id_accum_next    = id_accum_reg;
        id_negative_next = id_negative_reg;
        count_next       = count_reg;
        overflowed_next  = overflowed_reg;
        if (cmd.accept)
        begin
            if (is_newline)
            begin
                phase_next       = PH_WAIT;
                id_phase_next    = ID_SPACE;
                id_accum_next    = '0;
                id_negative_next = 1'b0;
                count_next       = '0;
                overflowed_next  = 1'b0;
            end
            else
            begin
                case (phase_reg)
                    PH_WAIT:
                    begin
                        if (rx_byte == CH_OPEN)
                        begin
                            phase_next = PH_ID;
                        end
                    end
                    PH_ID:
                    begin
                        if (rx_byte == CH_COLON)
                        begin
                            phase_next = PH_DATA;
                        end
                        else if (id_phase_reg == ID_SPACE && is_space)
                        begin
                            id_phase_next = ID_SPACE;
                        end
                        else if (id_phase_reg == ID_SPACE && is_sign)
                        begin
                            id_negative_next = (rx_byte == CH_MINUS);
                            id_phase_next    = ID_SIGN;
                        end
                        else if (id_phase_reg != ID_STOP)
                        begin
                            if (is_digit)
                            begin
                                id_accum_next = acc_step;
                                id_phase_next = ID_DIGITS;
                            end
                            else
                            begin
                                id_phase_next = ID_STOP;
                            end
                        end
                    end
                    PH_DATA:
                    begin
                        if (rx_byte == CH_CLOSE)
                        begin
                            phase_next = PH_DONE;
                        end
                        else if (count_reg < MAX_LEN)
                        begin
                            count_next = count_reg + LEN_W'(1);
                        end
                        else
                        begin
                            overflowed_next = 1'b1;
                        end
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        if (cmd.idx_clear)
        begin
            idx_next = '0;
        end
        else if (cmd.load_data)
        begin
            idx_next = idx_reg + LEN_W'(1);
        end
        else
        begin
            idx_next = idx_reg;
        end
        rd_addr = idx_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_WAIT;
            id_phase_reg    <= ID_SPACE;
            id_accum_reg    <= '0;
            id_negative_reg <= 1'b0;
            count_reg       <= '0;
            overflowed_reg  <= 1'b0;
            idx_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            phase_reg       <= phase_next;
            id_phase_reg    <= id_phase_next;
            id_accum_reg    <= id_accum_next;
            id_negative_reg <= id_negative_next;
            count_reg       <= count_next;
            overflowed_reg  <= overflowed_next;
            idx_reg         <= idx_next;
            if (cmd.load_header || cmd.load_data)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_en)
        begin
            mem[count_reg[IDX_W-1:0]] <= rx_byte;
        end
        if (rd_addr < MAX_LEN)
        begin
            mem_q_reg <= mem[rd_addr[IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && is_newline)
        begin
            snap_id_reg    <= id_negative_reg ? (8'd0 - id_accum_reg) : id_accum_reg;
            snap_len_reg   <= count_reg;
            snap_drop_reg  <= overflowed_reg || (phase_reg != PH_DONE);
            snap_cause_reg <= overflowed_reg ? CAUSE_OVERFLOW : CAUSE_MALFORMED;
        end
        if (cmd.load_header)
        begin
            kind_reg        <= snap_drop_reg ? KIND_DROP : KIND_HEADER;
            device_id_reg   <= snap_drop_reg ? '0 : snap_id_reg;
            payload_len_reg <= snap_drop_reg ? '0 : snap_len_reg;
            data_byte_reg   <= '0;
            drop_cause_reg  <= snap_drop_reg ? snap_cause_reg : CAUSE_MALFORMED;
            last_reg        <= snap_drop_reg || (snap_len_reg == '0);
        end
        else if (cmd.load_data)
        begin
            kind_reg        <= KIND_DATA;
            device_id_reg   <= snap_id_reg;
            payload_len_reg <= snap_len_reg;
            data_byte_reg   <= mem_q_reg;
            drop_cause_reg  <= CAUSE_MALFORMED;
            last_reg        <= sts.idx_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign kind        = kind_reg;
    assign device_id   = device_id_reg;
    assign payload_len = payload_len_reg;
    assign data_byte   = data_byte_reg;
    assign drop_cause  = drop_cause_reg;
    assign last        = last_reg;

    `LFP_ASSERT_IMPLY(a_load_when_free, cmd.load_header || cmd.load_data, out_free, "output item overwritten")
    `LFP_ASSERT_ALWAYS(a_count_bound, count_reg <= MAX_LEN, "payload count beyond buffer")
    `LFP_ASSERT_NEXT(a_newline_clears, cmd.accept && is_newline, (phase_reg == PH_WAIT) && (count_reg == '0), "line not cleared")

endmodule

@@ rtl/core/line_frame_id_payload_parser.sv @@
// An accepted newline is snapshotted, then its first result enters the output register.
// Throughput: one byte per cycle outside emission; payload results one per cycle if ready.
// A newline stalls input until its header (or drop) and payload results are all loaded.
// The output register lets the next line start while the final result waits.
// Reset (rst_n low, asynchronous) clears parser and control state; the buffer is not cleared.
module line_frame_id_payload_parser #(
    parameter int MAX_PAYLOAD = lfp_pkg::DEF_MAX_PAYLOAD
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] device_id, [13:8] payload_len,
                                        // [21:14] data_byte, [22] drop_cause, [23] zero
    output logic [1:0]  m_axis_tuser,   // [1:0] kind
    output logic        m_axis_tlast
);
    import lfp_pkg::*;

    lfp_cmd_t          cmd;
    lfp_sts_t          sts;
    logic [BYTE_W-1:0] device_id;
    logic [LEN_W-1:0]  payload_len;
    logic [BYTE_W-1:0] data_byte;
    logic              drop_cause;

    lfp_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .sts           (sts),
        .cmd           (cmd)
    );

    lfp_datapath #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .rx_byte     (s_axis_tdata),
        .out_ready   (m_axis_tready),
        .out_valid   (m_axis_tvalid),
        .kind        (m_axis_tuser),
        .device_id   (device_id),
        .payload_len (payload_len),
        .data_byte   (data_byte),
        .drop_cause  (drop_cause),
        .last        (m_axis_tlast)
    );

    assign m_axis_tdata = {1'b0, drop_cause, data_byte, payload_len, device_id};

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the line frame parser: directed and random lines vs. a byte predictor.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lfp_pkg::*;

    localparam int MAX_PAY      = DEF_MAX_PAYLOAD;
    localparam int RANDOM_BYTES = 130;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PRINT_LIMIT  = 30;

    typedef struct {
        logic [1:0] kind;
        logic [7:0] device_id;
        logic [5:0] payload_len;
        logic [7:0] data_byte;
        logic       drop_cause;
        logic       last;
    } frame_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] rx_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;           // [7:0] device_id, [13:8] payload_len,
                                         // [21:14] data_byte, [22] drop_cause, [23] zero
    logic [1:0]  m_axis_tuser;           // [1:0] kind
    logic        m_axis_tlast;

    // line predictor state
    lfp_phase_t    ln_phase = PH_WAIT;
    lfp_id_phase_t ln_id_phase = ID_SPACE;
    logic [7:0]    ln_id_mag = 8'h00;
    logic          ln_id_neg = 1'b0;
    logic [7:0]    ln_buf [MAX_PAY];
    int            ln_count = 0;
    logic          ln_over = 1'b0;

    frame_result_t expected_results [$];
    logic [7:0]    line_bytes [$];

    logic src_idle_on = 1'b1;
    logic sink_idle_on = 1'b1;
    logic sink_hold = 1'b0;
    int   sink_wait = 0;

    int cycle_count = 0;
    int mismatches = 0;
    int results_seen = 0;
    int bytes_sent = 0;
    int lines_sent = 0;
    int frames_expected = 0;
    int drops_expected = 0;

    line_frame_id_payload_parser i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still expected",
                     cycle_count, expected_results.size());
            $display("[line_frame_id_payload_parser] ERROR");
            $finish;
        end
    end

    function automatic logic is_id_space(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_VTAB || c == CH_FFEED || c == CH_CR;
    endfunction

    function automatic logic [7:0] space_char(input int k);
        case (k)
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_VTAB;
            3:       return CH_FFEED;
            default: return CH_CR;
        endcase
    endfunction

    function automatic logic [7:0] random_byte_except(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] c;
        do
        begin
            c = 8'($urandom_range(0, 255));
        end
        while (c == a || c == b);
        return c;
    endfunction

    task automatic push_expected(input logic [1:0] kind, input logic [7:0] id,
                                 input logic [5:0] len, input logic [7:0] data,
                                 input logic cause, input logic last);
        frame_result_t r;
        r.kind        = kind;
        r.device_id   = id;
        r.payload_len = len;
        r.data_byte   = data;
        r.drop_cause  = cause;
        r.last        = last;
        expected_results.push_back(r);
    endtask

    task automatic decode_id_char(input logic [7:0] c);
        logic digit;
        logic handled;
        digit   = c >= CH_ZERO && c <= CH_NINE;
        handled = 1'b0;
        if (ln_id_phase == ID_SPACE)
        begin
            if (is_id_space(c))
                handled = 1'b1;
            else if (c == CH_PLUS || c == CH_MINUS)
            begin
                ln_id_neg   = (c == CH_MINUS);
                ln_id_phase = ID_SIGN;
                handled     = 1'b1;
            end
        end
        if (!handled && ln_id_phase != ID_STOP)
        begin
            if (digit)
            begin
                ln_id_mag   = ln_id_mag * 8'd10 + (c - CH_ZERO);
                ln_id_phase = ID_DIGITS;
            end
            else
                ln_id_phase = ID_STOP;
        end
    endtask

    // advance the line predictor by one accepted byte
    task automatic predict_line_byte(input logic [7:0] c);
        logic [7:0] id;
        if (c == CH_NEWLINE)
        begin
            if (ln_over || ln_phase != PH_DONE)
            begin
                push_expected(KIND_DROP, 8'h00, 6'd0, 8'h00,
                              ln_over ? CAUSE_OVERFLOW : CAUSE_MALFORMED, 1'b1);
                drops_expected++;
            end
            else
            begin
                id = ln_id_neg ? 8'h00 - ln_id_mag : ln_id_mag;
                push_expected(KIND_HEADER, id, 6'(ln_count), 8'h00, 1'b0, ln_count == 0);
                for (int i = 0; i < ln_count; i++)
                    push_expected(KIND_DATA, id, 6'(ln_count), ln_buf[i], 1'b0,
                                  i + 1 == ln_count);
                frames_expected++;
            end
            ln_phase    = PH_WAIT;
            ln_id_phase = ID_SPACE;
            ln_id_mag   = 8'h00;
            ln_id_neg   = 1'b0;
            ln_count    = 0;
            ln_over     = 1'b0;
        end
        else
        begin
            case (ln_phase)
                PH_WAIT:
                    if (c == CH_OPEN)
                        ln_phase = PH_ID;
                PH_ID:
                    if (c == CH_COLON)
                        ln_phase = PH_DATA;
                    else
                        decode_id_char(c);
                PH_DATA:
                    if (c == CH_CLOSE)
                        ln_phase = PH_DONE;
                    else if (ln_count < MAX_PAY)
                    begin
                        ln_buf[ln_count] = c;
                        ln_count++;
                    end
                    else
                        ln_over = 1'b1;
                default:
                    ;
            endcase
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("mismatch at result %0d: %s got 0x%0h, expected 0x%0h",
                     results_seen, what, got, want);
    endtask

    always @(posedge clk)
    begin : check_results
        frame_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
            if (expected_results.size() == 0)
                report_mismatch("result with nothing expected", 32'(m_axis_tdata), 32'd0);
            else
            begin
                want = expected_results.pop_front();
                if (m_axis_tuser !== want.kind)
                    report_mismatch("kind", 32'(m_axis_tuser), 32'(want.kind));
                if (m_axis_tdata[7:0] !== want.device_id)
                    report_mismatch("device_id", 32'(m_axis_tdata[7:0]),
                                    32'(want.device_id));
                if (m_axis_tdata[13:8] !== want.payload_len)
                    report_mismatch("payload_len", 32'(m_axis_tdata[13:8]),
                                    32'(want.payload_len));
                if (m_axis_tdata[21:14] !== want.data_byte)
                    report_mismatch("data_byte", 32'(m_axis_tdata[21:14]),
                                    32'(want.data_byte));
                if (m_axis_tdata[22] !== want.drop_cause)
                    report_mismatch("drop_cause", 32'(m_axis_tdata[22]),
                                    32'(want.drop_cause));
                if (m_axis_tdata[23] !== 1'b0)
                    report_mismatch("pad bit", 32'(m_axis_tdata[23]), 32'd0);
                if (m_axis_tlast !== want.last)
                    report_mismatch("last", 32'(m_axis_tlast), 32'(want.last));
            end
        end
    end

    // receiver pacing: random wait per item when enabled, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            sink_wait = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                sink_wait = sink_idle_on ? $urandom_range(0, 15) : 0;
            if (sink_hold)
                m_axis_tready <= 1'b0;
            else if (sink_wait > 0)
            begin
                m_axis_tready <= 1'b0;
                sink_wait--;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    task automatic send_byte(input logic [7:0] c);
        int gap;
        gap = src_idle_on ? $urandom_range(0, 15) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        bytes_sent++;
        predict_line_byte(c);
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            line_bytes.push_back(s[i]);
    endtask

    task automatic send_line();
        foreach (line_bytes[i])
            send_byte(line_bytes[i]);
        line_bytes.delete();
        lines_sent++;
    endtask

    task automatic make_id_text(input logic long_id);
        int n;
        n = $urandom_range(0, 2);
        repeat (n) line_bytes.push_back(space_char($urandom_range(0, 4)));
        case ($urandom_range(0, 3))
            1:       line_bytes.push_back(CH_PLUS);
            2:       line_bytes.push_back(CH_MINUS);
            default: ;
        endcase
        n = long_id ? $urandom_range(3, 6) : $urandom_range(0, 3);
        repeat (n) line_bytes.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
        n = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
        repeat (n) line_bytes.push_back(random_byte_except(CH_COLON, CH_NEWLINE));
    endtask

    task automatic make_random_line();
        int shape;
        int n;
        int pick;
        logic drop_colon;
        logic drop_close;
        shape = $urandom_range(0, 9);
        if (shape == 8)
        begin
            n = $urandom_range(0, 12);
            repeat (n) line_bytes.push_back(random_byte_except(CH_NEWLINE, CH_NEWLINE));
        end
        else
        begin
            drop_colon = (shape == 7) && ($urandom_range(0, 1) == 1);
            drop_close = (shape == 7) && !drop_colon;
            n = $urandom_range(0, 3);
            repeat (n) line_bytes.push_back(random_byte_except(CH_OPEN, CH_NEWLINE));
            line_bytes.push_back(CH_OPEN);
            make_id_text(shape == 9);
            if (!drop_colon)
                line_bytes.push_back(CH_COLON);
            pick = $urandom_range(0, 19);
            if (pick < 14)
                n = $urandom_range(0, 8);
            else if (pick < 18)
                n = $urandom_range(9, MAX_PAY);
            else
                n = $urandom_range(MAX_PAY + 1, MAX_PAY + 4);
            repeat (n) line_bytes.push_back(random_byte_except(CH_CLOSE, CH_NEWLINE));
            if (!drop_close)
                line_bytes.push_back(CH_CLOSE);
            n = $urandom_range(0, 2);
            repeat (n) line_bytes.push_back(random_byte_except(CH_NEWLINE, CH_NEWLINE));
        end
        line_bytes.push_back(CH_NEWLINE);
    endtask

    task automatic test_frames();
        push_text("<5:AB>\n");
        send_line();
        push_text("<7:>\n");
        send_line();
        push_text("<0:");
        line_bytes.push_back(8'h00);
        line_bytes.push_back(8'hFF);
        line_bytes.push_back(CH_OPEN);
        line_bytes.push_back(CH_COLON);
        line_bytes.push_back(8'h7F);
        line_bytes.push_back(8'h80);
        push_text(">\n");
        send_line();
    endtask

    task automatic test_id_decoding();
        push_text("<");
        line_bytes.push_back(CH_SPACE);
        line_bytes.push_back(CH_TAB);
        line_bytes.push_back(CH_VTAB);
        line_bytes.push_back(CH_FFEED);
        line_bytes.push_back(CH_CR);
        push_text("-12:x>\n");
        send_line();
        push_text("<+300:>\n");
        send_line();
        push_text("<abc:>\n");
        send_line();
        push_text("<4>2:>\n");
        send_line();
        push_text("<-:>\n");
        send_line();
        push_text("<--5:z>\n");
        send_line();
        push_text("<255:>\n");
        send_line();
        push_text("<-128:>\n");
        send_line();
        push_text("<99999:>\n");
        send_line();
        push_text("<:>\n");
        send_line();
    endtask

    task automatic test_malformed();
        push_text("\n");
        send_line();
        push_text("junk\n");
        send_line();
        push_text("<12:ab\n");
        send_line();
        push_text("<12ab>\n");
        send_line();
        push_text("x<3:q>tail\n");
        send_line();
    endtask

    task automatic test_overflow();
        for (int len = MAX_PAY; len <= MAX_PAY + 2; len++)
        begin
            push_text("<1:");
            repeat (len) line_bytes.push_back(random_byte_except(CH_CLOSE, CH_NEWLINE));
            if (len <= MAX_PAY + 1)
                line_bytes.push_back(CH_CLOSE);
            line_bytes.push_back(CH_NEWLINE);
            send_line();
        end
    endtask

    task automatic test_backpressure();
        fork
            begin
                sink_hold <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                sink_hold <= 1'b0;
            end
            begin
                repeat (6)
                begin
                    push_text("<9:");
                    repeat ($urandom_range(10, 24))
                        line_bytes.push_back(random_byte_except(CH_CLOSE, CH_NEWLINE));
                    push_text(">\n");
                    send_line();
                end
            end
        join
    endtask

    task automatic test_random_lines();
        int start_bytes;
        int mode;
        start_bytes = bytes_sent;
        while (bytes_sent - start_bytes < RANDOM_BYTES)
        begin
            if (lines_sent % 8 == 0)
            begin
                mode = $urandom_range(0, 3);
                src_idle_on  <= mode[0];
                sink_idle_on <= mode[1];
            end
            make_random_line();
            send_line();
        end
        src_idle_on  <= 1'b1;
        sink_idle_on <= 1'b1;
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_frames();
        test_id_decoding();
        test_malformed();
        test_overflow();
        test_backpressure();
        test_random_lines();
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("run: %0d lines, %0d bytes in; %0d frames and %0d dropped lines predicted",
                 lines_sent, bytes_sent, frames_expected, drops_expected);
        $display("run: %0d results checked, %0d mismatches", results_seen, mismatches);
        if (mismatches == 0)
            $display("[line_frame_id_payload_parser] OK");
        else
            $display("[line_frame_id_payload_parser] ERROR");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/lfp_pkg.sv
rtl/core/lfp_ctrl.sv
rtl/core/lfp_datapath.sv
rtl/core/line_frame_id_payload_parser.sv
tb/tb.sv
